@@ sv/octree_point_insert_defines.svh @@
// Assertion macros shared by the octree point insert RTL
`ifndef OCTREE_POINT_INSERT_DEFINES_SVH
`define OCTREE_POINT_INSERT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define OPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("octree_point_insert: assertion failed");

// Next-cycle implication, checked outside reset
`define OPI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("octree_point_insert: assertion failed");

`endif

@@ sv/opi_pkg.sv @@
// Shared types, constants and codes of the octree point insert block
package opi_pkg;

   localparam int NODE_COUNT = 4096;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int FREE_W     = NODE_AW + 1;
   localparam int MAX_DEPTH  = 17;
   localparam int DEPTH_W    = 5;
   localparam int CODE_W     = 3 * MAX_DEPTH;
   localparam int COORD_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int MODE_W     = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [DEPTH_W-1:0] DEPTH_LIM  = DEPTH_W'(MAX_DEPTH);
   localparam logic [MODE_W-1:0]  MODE_RESET = MODE_W'(17);

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MAX_Y = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_MAX_Z = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_CAP   = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_MODE  = 3'd7;

   // command and status codes
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;
   localparam logic STAT_DONE   = 1'b0;
   localparam logic STAT_DROP   = 1'b1;

   typedef logic [7:0][NODE_AW-1:0] links_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLR,
      S_RD,
      S_CHK,
      S_AXIS,
      S_NEXT,
      S_LINK,
      S_OUT
   } state_type;

   // write requests from the sequencer to the node store
   typedef struct packed {
      logic               cnt_we;
      logic [NODE_AW-1:0] cnt_addr;
      logic [COUNT_W-1:0] cnt_data;
      logic [7:0]         row_mask;
      logic [NODE_AW-1:0] row_addr;
      logic [NODE_AW-1:0] row_data;
   } store_wr_type;

endpackage

@@ sv/opi_ifs.sv @@
// Valid/ready channel interfaces for insert requests and path responses
interface opi_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic signed [opi_pkg::COORD_W-1:0]   point_x;
   logic signed [opi_pkg::COORD_W-1:0]   point_y;
   logic signed [opi_pkg::COORD_W-1:0]   point_z;

   modport source (output valid, cmd, point_x, point_y, point_z, input ready);
   modport sink   (input valid, cmd, point_x, point_y, point_z, output ready);
endinterface

interface opi_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] path_code;
   logic        status;

   modport source (output valid, path_code, status, input ready);
   modport sink   (input valid, path_code, status, output ready);
endinterface

@@ sv/opi_store.sv @@
// Node store: per-node point counts and rows of eight child links
module opi_store (
   input  logic                               clock,
   input  opi_pkg::store_wr_type              wr,
   input  logic [opi_pkg::NODE_AW-1:0]        rd_addr,
   output logic [opi_pkg::COUNT_W-1:0]        cnt_rd,
   output opi_pkg::links_type                 row_rd
);

   logic [opi_pkg::COUNT_W-1:0] cnt_mem [opi_pkg::NODE_COUNT];
   opi_pkg::links_type          row_mem [opi_pkg::NODE_COUNT];
   logic [opi_pkg::COUNT_W-1:0] cnt_rd_ff;
   opi_pkg::links_type          row_rd_ff;

   // count memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr.cnt_we) begin
         cnt_mem[wr.cnt_addr] <= wr.cnt_data;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   // link memory: lane-masked write, registered row read
   always_ff @(posedge clock) begin
      for (int l = 0; l < 8; l++) begin
         if (wr.row_mask[l]) begin
            row_mem[wr.row_addr][l] <= wr.row_data;
         end
      end
      row_rd_ff <= row_mem[rd_addr];
   end

   assign cnt_rd = cnt_rd_ff;
   assign row_rd = row_rd_ff;

endmodule

@@ sv/opi_axis.sv @@
// Shared axis unit: floor midpoint of a box span and upper-half compare
module opi_axis (
   input  logic signed [opi_pkg::COORD_W-1:0] lo,
   input  logic signed [opi_pkg::COORD_W-1:0] hi,
   input  logic signed [opi_pkg::COORD_W-1:0] pt,
   output logic signed [opi_pkg::COORD_W-1:0] mid,
   output logic                               upper
);

   logic signed [opi_pkg::COORD_W:0] sum;

   // sum in one extra bit; dropping the low bit is an arithmetic floor halve
   assign sum   = {lo[opi_pkg::COORD_W-1], lo} + {hi[opi_pkg::COORD_W-1], hi};
   assign mid   = sum[opi_pkg::COORD_W:1];
   assign upper = pt > mid;

endmodule

@@ sv/octree_point_insert.sv @@
// Top level: bucketed octree point insertion sequencer
//
//   port        dir   handshake      payload
//   req_chan    in    valid/ready    cmd, point_x, point_y, point_z
//   rsp_chan    out   valid/ready    path_code, status
//   csr_*       in    csr_we         csr_index, csr_wdata
//
// An insert walks one tree level per pass: node read, one axis per cycle through
// the shared midpoint unit, then the link step, with a further link state when
// a child node is allocated. After reset the root row is wiped before the first
// item is taken. The result sits in an output register; a stalled response
// holds the sequencer in its output step, and no new item is taken until the
// walk ends.
`include "octree_point_insert_defines.svh"

module octree_point_insert (
   input  logic                              clock,
   input  logic                              reset,
   opi_req_if.sink                           req_chan,
   opi_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [opi_pkg::CSR_AW-1:0]        csr_index,
   input  logic [opi_pkg::CSR_DW-1:0]        csr_wdata
);

   localparam int CW = opi_pkg::COORD_W;
   localparam int AW = opi_pkg::NODE_AW;

   // configuration registers
   logic signed [CW-1:0]              box_min_ff [3];
   logic signed [CW-1:0]              box_max_ff [3];
   logic [opi_pkg::COUNT_W-1:0]       cap_cfg_ff;
   logic [opi_pkg::MODE_W-1:0]        mode_ff;

   // walk state
   opi_pkg::state_type                state_ff, state_in;
   logic [AW-1:0]                     node_ff, node_in;
   logic [opi_pkg::FREE_W-1:0]        free_ff, free_in;
   logic [opi_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic [opi_pkg::CODE_W-1:0]        code_ff, code_in;
   logic [2:0]                        oct_ff, oct_in;
   logic [1:0]                        axis_ff, axis_in;
   logic signed [CW-1:0]              lo_ff [3];
   logic signed [CW-1:0]              lo_in [3];
   logic signed [CW-1:0]              hi_ff [3];
   logic signed [CW-1:0]              hi_in [3];
   logic signed [CW-1:0]              pt_ff [3];
   logic signed [CW-1:0]              pt_in [3];
   logic [63:0]                       res_path_ff, res_path_in;
   logic                              res_stat_ff, res_stat_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [63:0]                       rsp_path_ff;
   logic                              rsp_stat_ff;

   logic                              req_acc;
   logic                              rsp_load;
   logic                              leaves_only;
   logic [opi_pkg::DEPTH_W-1:0]       limit;
   logic [opi_pkg::COUNT_W-1:0]       cap;
   logic [opi_pkg::CODE_W-1:0]        code_nx;
   logic [opi_pkg::DEPTH_W-1:0]       depth_nx;
   logic [63:0]                       path_now, path_nx;
   logic [AW-1:0]                     child;

   opi_pkg::store_wr_type             wr;
   logic [opi_pkg::COUNT_W-1:0]       cnt_rd;
   opi_pkg::links_type                row_rd;
   logic signed [CW-1:0]              ax_mid;
   logic                              ax_upper;

   opi_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (node_ff),
      .cnt_rd  (cnt_rd),
      .row_rd  (row_rd)
   );

   opi_axis u_axis (
      .lo    (lo_ff[axis_ff]),
      .hi    (hi_ff[axis_ff]),
      .pt    (pt_ff[axis_ff]),
      .mid   (ax_mid),
      .upper (ax_upper)
   );

   // decode build mode
   assign leaves_only = mode_ff[5];
   assign limit = (mode_ff[4:0] == '0 || mode_ff[4:0] > opi_pkg::DEPTH_LIM)
                  ? opi_pkg::DEPTH_LIM : mode_ff[4:0];
   assign cap   = leaves_only ? '0 : cap_cfg_ff;

   // path code forms: as walked so far, and with the current octant appended
   assign code_nx  = {code_ff[opi_pkg::CODE_W-4:0], oct_ff};
   assign depth_nx = depth_ff + 1'b1;
   assign path_now = {(leaves_only ? 8'd0 : {3'd0, depth_ff}), 5'd0, code_ff};
   assign path_nx  = {(leaves_only ? 8'd0 : {3'd0, depth_nx}), 5'd0, code_nx};
   assign child    = row_rd[oct_ff];

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == opi_pkg::S_IDLE);
   assign rsp_load = (state_ff == opi_pkg::S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= '{default: '0};
         box_max_ff <= '{default: '0};
         cap_cfg_ff <= '0;
         mode_ff    <= opi_pkg::MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            opi_pkg::CSR_MIN_X: box_min_ff[0] <= csr_wdata;
            opi_pkg::CSR_MIN_Y: box_min_ff[1] <= csr_wdata;
            opi_pkg::CSR_MIN_Z: box_min_ff[2] <= csr_wdata;
            opi_pkg::CSR_MAX_X: box_max_ff[0] <= csr_wdata;
            opi_pkg::CSR_MAX_Y: box_max_ff[1] <= csr_wdata;
            opi_pkg::CSR_MAX_Z: box_max_ff[2] <= csr_wdata;
            opi_pkg::CSR_CAP:   cap_cfg_ff    <= csr_wdata;
            opi_pkg::CSR_MODE:  mode_ff       <= csr_wdata[opi_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opi_pkg::S_INIT;
         free_ff  <= opi_pkg::FREE_W'(1);
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         depth_ff <= depth_in;
      end
   end

   // walk payload registers
   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      code_ff     <= code_in;
      oct_ff      <= oct_in;
      axis_ff     <= axis_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      pt_ff       <= pt_in;
      res_path_ff <= res_path_in;
      res_stat_ff <= res_stat_in;
   end

   // next state, store writes and result
   always_comb begin
      state_in    = state_ff;
      node_in     = node_ff;
      free_in     = free_ff;
      depth_in    = depth_ff;
      code_in     = code_ff;
      oct_in      = oct_ff;
      axis_in     = axis_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pt_in       = pt_ff;
      res_path_in = res_path_ff;
      res_stat_in = res_stat_ff;
      wr          = '0;

      unique case (state_ff)
         opi_pkg::S_INIT: begin
            // wipe root count and links after reset
            wr.cnt_we   = 1'b1;
            wr.row_mask = '1;
            free_in     = opi_pkg::FREE_W'(1);
            state_in    = opi_pkg::S_IDLE;
         end
         opi_pkg::S_IDLE: begin
            if (req_acc) begin
               if (req_chan.cmd == opi_pkg::CMD_CLEAR) begin
                  state_in = opi_pkg::S_CLR;
               end else begin
                  pt_in    = '{req_chan.point_x, req_chan.point_y, req_chan.point_z};
                  lo_in    = box_min_ff;
                  hi_in    = box_max_ff;
                  node_in  = '0;
                  depth_in = '0;
                  code_in  = '0;
                  state_in = opi_pkg::S_RD;
               end
            end
         end
         opi_pkg::S_CLR: begin
            // restart the tree at an empty root
            wr.cnt_we   = 1'b1;
            wr.row_mask = '1;
            free_in     = opi_pkg::FREE_W'(1);
            res_path_in = '0;
            res_stat_in = opi_pkg::STAT_DONE;
            state_in    = opi_pkg::S_OUT;
         end
         opi_pkg::S_RD: begin
            state_in = opi_pkg::S_CHK;
         end
         opi_pkg::S_CHK: begin
            if (cnt_rd < cap) begin
               // node has room: keep the point here
               wr.cnt_we   = 1'b1;
               wr.cnt_addr = node_ff;
               wr.cnt_data = cnt_rd + 1'b1;
               res_path_in = path_now;
               res_stat_in = opi_pkg::STAT_DONE;
               state_in    = opi_pkg::S_OUT;
            end else begin
               axis_in  = '0;
               state_in = opi_pkg::S_AXIS;
            end
         end
         opi_pkg::S_AXIS: begin
            // one axis per cycle: pick half, shrink box
            oct_in[axis_ff] = ax_upper;
            if (ax_upper) begin
               lo_in[axis_ff] = ax_mid;
            end else begin
               hi_in[axis_ff] = ax_mid;
            end
            if (axis_ff == 2'd2) begin
               state_in = opi_pkg::S_NEXT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         opi_pkg::S_NEXT: begin
            code_in  = code_nx;
            depth_in = depth_nx;
            if (depth_nx == limit) begin
               // level limit: current node takes the point, saturating
               wr.cnt_we   = (cnt_rd != opi_pkg::COUNT_MAX);
               wr.cnt_addr = node_ff;
               wr.cnt_data = cnt_rd + 1'b1;
               res_path_in = path_nx;
               res_stat_in = opi_pkg::STAT_DONE;
               state_in    = opi_pkg::S_OUT;
            end else if (child != '0) begin
               node_in  = child;
               state_in = opi_pkg::S_RD;
            end else if (free_ff[AW]) begin
               // pool exhausted: drop the point
               res_path_in = '0;
               res_stat_in = opi_pkg::STAT_DROP;
               state_in    = opi_pkg::S_OUT;
            end else begin
               // allocate: clear the new node's count and links
               wr.cnt_we   = 1'b1;
               wr.cnt_addr = free_ff[AW-1:0];
               wr.row_mask = '1;
               wr.row_addr = free_ff[AW-1:0];
               state_in    = opi_pkg::S_LINK;
            end
         end
         opi_pkg::S_LINK: begin
            // hook the new node under its parent and descend
            wr.row_mask = 8'(1) << oct_ff;
            wr.row_addr = node_ff;
            wr.row_data = free_ff[AW-1:0];
            node_in     = free_ff[AW-1:0];
            free_in     = free_ff + 1'b1;
            state_in    = opi_pkg::S_RD;
         end
         opi_pkg::S_OUT: begin
            if (rsp_load) begin
               state_in = opi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = opi_pkg::S_IDLE;
         end
      endcase
   end

   // output register: hold the item until taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_path_ff <= res_path_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.path_code = rsp_path_ff;
   assign rsp_chan.status    = rsp_stat_ff;

   // the free pointer never runs past the pool
   `OPI_ASSERT_IMP(a_free_bound, clock, reset, 1'b1,
      free_ff <= opi_pkg::FREE_W'(opi_pkg::NODE_COUNT))
   // a node is only linked while the pool has room
   `OPI_ASSERT_IMP(a_link_room, clock, reset, state_ff == opi_pkg::S_LINK,
      free_ff < opi_pkg::FREE_W'(opi_pkg::NODE_COUNT))
   // the walk depth never exceeds the maximum level limit
   `OPI_ASSERT_IMP(a_depth_bound, clock, reset, state_ff != opi_pkg::S_IDLE,
      depth_ff <= opi_pkg::DEPTH_LIM)
   // a response appears only from the output step
   `OPI_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == opi_pkg::S_OUT)

endmodule

@@ verif/tb_octree_point_insert.sv @@
// Testbench for octree_point_insert: directed table, random phases, self-checking predictor
`timescale 1ns / 100ps

module tb_octree_point_insert;

   localparam logic signed [31:0] MIN_COORD = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_COORD = 32'sh7FFF_FFFF;
   localparam logic [5:0] LEAVES_ONLY = 6'h20;
   localparam logic [5:0] FULL_LIMIT = 6'd17;

   // paths known without walking the tree
   localparam logic [63:0] ROOT_PATH = 64'h0;
   localparam logic [63:0] ALL_LOW_PATH = 64'h1100_0000_0000_0000;
   localparam logic [63:0] ALL_HIGH_PATH = 64'h1107_FFFF_FFFF_FFFF;
   localparam logic [63:0] ONE_LOW_PATH = 64'h0100_0000_0000_0000;
   localparam logic [63:0] ONE_HIGH_PATH = 64'h0100_0000_0000_0007;

   // preset configurations of the directed table
   localparam int CFG_ROOT_HOLD = 0;
   localparam int CFG_LEAVES = 1;
   localparam int CFG_ONE_LEVEL = 2;
   localparam int CFG_INVERTED = 3;
   localparam int CFG_TINY_BOX = 4;
   localparam int CFG_FLAT_BOX = 5;

   localparam int NUM_PHASES = 10;
   localparam int POOL_PHASE = 4;
   localparam int PHASE_ITEMS = 72;
   localparam int POOL_ITEMS = 500;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct packed {
      logic [63:0] code;
      logic        status;
   } path_type;

   typedef struct {
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
      logic [31:0]        cap;
      logic [5:0]         mode;
   } tree_cfg_type;

   typedef struct {
      bit          load;
      int          cfg_id;
      logic        cmd;
      point_type   pt;
      bit          typed;
      logic [63:0] code;
      logic        status;
   } probe_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [opi_pkg::CSR_AW-1:0] csr_index;
   logic [opi_pkg::CSR_DW-1:0] csr_wdata;

   opi_req_if req_bus ();
   opi_rsp_if rsp_bus ();

   octree_point_insert i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow tree and configuration
   logic [opi_pkg::COUNT_W-1:0] node_count_m [opi_pkg::NODE_COUNT];
   logic [opi_pkg::NODE_AW-1:0] child_link_m [opi_pkg::NODE_COUNT*8];
   int unsigned                 free_m;
   tree_cfg_type                live_cfg;

   path_type      pending_paths [$];
   point_type     recent_points [$];
   probe_row_type probe_rows [$];
   tree_cfg_type  presets [6];
   int            mismatch_count = 0;
   bit            idle_ok = 1'b1;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // walk the shadow tree for one item and return the path it yields
   function automatic void walk_octree(input logic cmd, input point_type pt,
                                       output logic [63:0] code_o, output logic stat_o);
      longint      lo [3];
      longint      hi [3];
      longint      pos [3];
      longint      mid;
      int unsigned limit, node, child, slot, lvl;
      logic [31:0] cap;
      logic        leaves;
      logic [63:0] path, level_path;
      logic [2:0]  oct;
      code_o = '0;
      stat_o = opi_pkg::STAT_DONE;
      if (cmd == opi_pkg::CMD_CLEAR) begin
         node_count_m[0] = '0;
         for (int i = 0; i < 8; i++) child_link_m[i] = '0;
         free_m = 1;
         return;
      end
      pos[0] = $signed(pt.x);
      pos[1] = $signed(pt.y);
      pos[2] = $signed(pt.z);
      for (int a = 0; a < 3; a++) begin
         lo[a] = $signed(live_cfg.lo[a]);
         hi[a] = $signed(live_cfg.hi[a]);
      end
      limit = live_cfg.mode[4:0];
      if (limit == 0 || limit > opi_pkg::MAX_DEPTH) limit = opi_pkg::MAX_DEPTH;
      leaves = live_cfg.mode[5];
      cap = leaves ? '0 : live_cfg.cap;
      node = 0;
      path = '0;
      level_path = '0;
      for (lvl = 0; lvl < limit; lvl++) begin
         // node still has room: keep the point here
         if (node_count_m[node] < cap) begin
            node_count_m[node]++;
            code_o = level_path;
            return;
         end
         // pick the octant against the floor midpoint and shrink the box
         oct = '0;
         for (int a = 0; a < 3; a++) begin
            mid = (lo[a] + hi[a]) >>> 1;
            if (pos[a] > mid) begin
               oct[a] = 1'b1;
               lo[a] = mid;
            end else begin
               hi[a] = mid;
            end
         end
         path = {path[60:0], oct};
         level_path = path;
         if (!leaves) level_path[63:56] = 8'(lvl + 1);
         // level limit: count saturates
         if (lvl + 1 == limit) begin
            if (node_count_m[node] != opi_pkg::COUNT_MAX) node_count_m[node]++;
            break;
         end
         slot = node * 8 + oct;
         child = child_link_m[slot];
         if (child == 0) begin
            if (free_m >= opi_pkg::NODE_COUNT) begin
               code_o = '0;
               stat_o = opi_pkg::STAT_DROP;
               return;
            end
            child = free_m;
            free_m++;
            node_count_m[child] = '0;
            for (int i = 0; i < 8; i++) child_link_m[child*8 + i] = '0;
            child_link_m[slot] = opi_pkg::NODE_AW'(child);
         end
         node = child;
      end
      code_o = level_path;
   endfunction

   function automatic point_type mk_pt(input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic tree_cfg_type cube_cfg(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi,
                                             input logic [31:0] cap, input logic [5:0] mode);
      tree_cfg_type c;
      for (int a = 0; a < 3; a++) begin
         c.lo[a] = lo;
         c.hi[a] = hi;
      end
      c.cap = cap;
      c.mode = mode;
      return c;
   endfunction

   function automatic tree_cfg_type random_cfg();
      tree_cfg_type c;
      logic signed [31:0] t;
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(0, 4))
            0: begin
               c.lo[a] = MIN_COORD;
               c.hi[a] = MAX_COORD;
            end
            1: begin
               c.lo[a] = $urandom;
               c.hi[a] = c.lo[a] + $urandom_range(0, 1000);
            end
            2: begin
               c.lo[a] = $urandom;
               c.hi[a] = $urandom;
            end
            3: begin
               c.lo[a] = $urandom;
               c.hi[a] = c.lo[a];
            end
            default: begin
               c.lo[a] = $signed($urandom_range(0, 200)) - 100;
               c.hi[a] = c.lo[a] + $urandom_range(0, 60);
            end
         endcase
         // occasionally invert the axis
         if ($urandom_range(0, 7) == 0) begin
            t = c.lo[a];
            c.lo[a] = c.hi[a];
            c.hi[a] = t;
         end
      end
      case ($urandom_range(0, 4))
         0: c.cap = '0;
         1: c.cap = $urandom_range(1, 4);
         2: c.cap = $urandom_range(5, 40);
         3: c.cap = $urandom;
         default: c.cap = '1;
      endcase
      if ($urandom_range(0, 3) == 0) c.mode = 6'($urandom_range(0, 63));
      else c.mode = {1'($urandom_range(0, 1)), 5'($urandom_range(1, 17))};
      return c;
   endfunction

   // coordinate mostly inside the current box, sometimes anywhere or at an extreme
   function automatic logic signed [31:0] pick_coord(input int axis);
      longint a, b, span, v;
      a = $signed(live_cfg.lo[axis]);
      b = $signed(live_cfg.hi[axis]);
      if (a > b) begin
         v = a;
         a = b;
         b = v;
      end
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return MIN_COORD;
               1: return MAX_COORD;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: begin
            span = b - a + 5;
            v = a - 2 + (longint'({$urandom, $urandom} >> 1) % span);
            if (v > longint'(MAX_COORD)) v = MAX_COORD;
            if (v < longint'(MIN_COORD)) v = MIN_COORD;
            return v[31:0];
         end
      endcase
   endfunction

   task automatic row_cfg(input int id);
      probe_row_type r;
      r = '{default: '0};
      r.load = 1'b1;
      r.cfg_id = id;
      probe_rows.insert(probe_rows.size(), r);
   endtask

   task automatic row_item(input logic cmd, input point_type pt);
      probe_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.pt = pt;
      probe_rows.insert(probe_rows.size(), r);
   endtask

   task automatic row_typed(input logic cmd, input point_type pt, input logic [63:0] code,
                            input logic status);
      probe_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.pt = pt;
      r.typed = 1'b1;
      r.code = code;
      r.status = status;
      probe_rows.insert(probe_rows.size(), r);
   endtask

   task automatic put_reg(input logic [opi_pkg::CSR_AW-1:0] idx,
                          input logic [opi_pkg::CSR_DW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_config(input tree_cfg_type cfg);
      live_cfg = cfg;
      put_reg(opi_pkg::CSR_MIN_X, cfg.lo[0]);
      put_reg(opi_pkg::CSR_MIN_Y, cfg.lo[1]);
      put_reg(opi_pkg::CSR_MIN_Z, cfg.lo[2]);
      put_reg(opi_pkg::CSR_MAX_X, cfg.hi[0]);
      put_reg(opi_pkg::CSR_MAX_Y, cfg.hi[1]);
      put_reg(opi_pkg::CSR_MAX_Z, cfg.hi[2]);
      put_reg(opi_pkg::CSR_CAP, cfg.cap);
      put_reg(opi_pkg::CSR_MODE, opi_pkg::CSR_DW'(cfg.mode));
      csr_we <= 1'b0;
   endtask

   // drop valid, wait for every outstanding path, then let the output step finish
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // offer one item, predict its path once it is taken
   task automatic send_item(input logic cmd, input point_type pt, input bit typed,
                            input logic [63:0] code, input logic status);
      path_type    want;
      logic [63:0] pred_code;
      logic        pred_status;
      if (idle_ok && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.point_x <= pt.x;
      req_bus.point_y <= pt.y;
      req_bus.point_z <= pt.z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      walk_octree(cmd, pt, pred_code, pred_status);
      want.code = typed ? code : pred_code;
      want.status = typed ? status : pred_status;
      pending_paths.insert(pending_paths.size(), want);
   endtask

   // response back-pressure in random bursts
   initial begin : rsp_stall
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each accepted response with the oldest expected path
   always @(posedge clock) begin : rsp_check
      path_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_paths.size() == 0) begin
            $error("unexpected response: path_code %h status %b",
                   rsp_bus.path_code, rsp_bus.status);
            mismatch_count++;
         end else begin
            want = pending_paths.pop_front();
            if (rsp_bus.path_code !== want.code) begin
               $error("path_code: expected %h, actual %h", want.code, rsp_bus.path_code);
               mismatch_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %b, actual %b", want.status, rsp_bus.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      tree_cfg_type cfg;
      point_type    pt;
      int           n_items;
      bit           do_clear;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = opi_pkg::CMD_INSERT;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;

      // shadow state after reset
      for (int i = 0; i < opi_pkg::NODE_COUNT; i++) node_count_m[i] = '0;
      for (int i = 0; i < opi_pkg::NODE_COUNT*8; i++) child_link_m[i] = '0;
      free_m = 1;
      live_cfg = cube_cfg(32'sd0, 32'sd0, '0, opi_pkg::MODE_RESET);

      presets[CFG_ROOT_HOLD] = cube_cfg(MIN_COORD, MAX_COORD, '1, FULL_LIMIT);
      presets[CFG_LEAVES] = cube_cfg(MIN_COORD, MAX_COORD, '1, LEAVES_ONLY);
      presets[CFG_ONE_LEVEL] = cube_cfg(MIN_COORD, MAX_COORD, '0, 6'd1);
      presets[CFG_INVERTED] = cube_cfg(MAX_COORD, MIN_COORD, 32'd1, 6'd3);
      presets[CFG_TINY_BOX] = cube_cfg(32'sd0, 32'sd15, 32'd2, 6'h1F);
      presets[CFG_FLAT_BOX] = cube_cfg(-32'sd7, -32'sd7, '0, 6'h3F);

      // reset configuration: zero box, every level taken down to the limit
      row_typed(opi_pkg::CMD_INSERT, mk_pt(0, 0, 0), ALL_LOW_PATH, opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(1, 1, 1), ALL_HIGH_PATH, opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(MAX_COORD, MAX_COORD, MAX_COORD), ALL_HIGH_PATH,
                opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(MIN_COORD, MIN_COORD, MIN_COORD), ALL_LOW_PATH,
                opi_pkg::STAT_DONE);
      row_item(opi_pkg::CMD_INSERT, mk_pt(1, 0, -1));
      row_typed(opi_pkg::CMD_CLEAR, mk_pt(MAX_COORD, 0, MIN_COORD), ROOT_PATH,
                opi_pkg::STAT_DONE);
      // huge capacity: root keeps everything
      row_cfg(CFG_ROOT_HOLD);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(MAX_COORD, MIN_COORD, 0), ROOT_PATH,
                opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(MIN_COORD, MAX_COORD, -1), ROOT_PATH,
                opi_pkg::STAT_DONE);
      // leaves-only overrides the capacity and drops the level count
      row_cfg(CFG_LEAVES);
      row_item(opi_pkg::CMD_INSERT, mk_pt(MAX_COORD, MAX_COORD, MAX_COORD));
      row_item(opi_pkg::CMD_INSERT, mk_pt(MIN_COORD, 0, MAX_COORD));
      row_item(opi_pkg::CMD_INSERT, mk_pt(12345, -678, 9));
      // single level over the full box: midpoint is -1
      row_cfg(CFG_ONE_LEVEL);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(5, 5, 5), ONE_HIGH_PATH, opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(-1, -1, -1), ONE_LOW_PATH, opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(0, 0, 0), ONE_HIGH_PATH, opi_pkg::STAT_DONE);
      row_typed(opi_pkg::CMD_INSERT, mk_pt(MIN_COORD, MIN_COORD, MIN_COORD), ONE_LOW_PATH,
                opi_pkg::STAT_DONE);
      // inverted box
      row_cfg(CFG_INVERTED);
      row_item(opi_pkg::CMD_INSERT, mk_pt(0, -1, 1));
      row_item(opi_pkg::CMD_INSERT, mk_pt(0, -1, 1));
      row_item(opi_pkg::CMD_INSERT, mk_pt(MAX_COORD, MIN_COORD, 77));
      // tiny box, capacity 2, out-of-range limit
      row_cfg(CFG_TINY_BOX);
      row_item(opi_pkg::CMD_INSERT, mk_pt(3, 3, 3));
      row_item(opi_pkg::CMD_INSERT, mk_pt(3, 3, 3));
      row_item(opi_pkg::CMD_INSERT, mk_pt(3, 3, 3));
      row_item(opi_pkg::CMD_INSERT, mk_pt(15, 0, 7));
      row_typed(opi_pkg::CMD_CLEAR, mk_pt(0, 0, 0), ROOT_PATH, opi_pkg::STAT_DONE);
      // degenerate box with every mode bit set
      row_cfg(CFG_FLAT_BOX);
      row_item(opi_pkg::CMD_INSERT, mk_pt(-7, -7, -7));
      row_item(opi_pkg::CMD_INSERT, mk_pt(-6, -8, 100));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (probe_rows[r]) begin
         if (probe_rows[r].load) begin
            drain();
            load_config(presets[probe_rows[r].cfg_id]);
         end else begin
            send_item(probe_rows[r].cmd, probe_rows[r].pt, probe_rows[r].typed,
                      probe_rows[r].code, probe_rows[r].status);
         end
      end

      // random phases; one phase fills the node pool with deep leaves-only walks
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         idle_ok = (ph != NUM_PHASES - 1);
         if (ph == POOL_PHASE) begin
            cfg = cube_cfg(MIN_COORD, MAX_COORD, $urandom, LEAVES_ONLY | FULL_LIMIT);
            n_items = POOL_ITEMS;
         end else begin
            cfg = random_cfg();
            n_items = PHASE_ITEMS;
         end
         load_config(cfg);
         for (int i = 0; i < n_items; i++) begin
            if (ph == POOL_PHASE) do_clear = (i == 0);
            else do_clear = ($urandom_range(0, 39) == 0);
            if (do_clear) begin
               send_item(opi_pkg::CMD_CLEAR, mk_pt($urandom, $urandom, $urandom), 1'b0, '0,
                         opi_pkg::STAT_DONE);
            end else begin
               if (ph != POOL_PHASE && recent_points.size() > 0 && $urandom_range(0, 4) == 0)
               begin
                  pt = recent_points[$urandom_range(0, recent_points.size() - 1)];
               end else begin
                  pt = mk_pt(pick_coord(0), pick_coord(1), pick_coord(2));
                  recent_points.insert(recent_points.size(), pt);
                  if (recent_points.size() > 16) void'(recent_points.pop_front());
               end
               send_item(opi_pkg::CMD_INSERT, pt, 1'b0, '0, opi_pkg::STAT_DONE);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_octree_point_insert: clean");
      end else begin
         $display("tb_octree_point_insert: errors");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("tb_octree_point_insert: errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/opi_pkg.sv
sv/opi_ifs.sv
sv/opi_store.sv
sv/opi_axis.sv
sv/octree_point_insert.sv
verif/tb_octree_point_insert.sv
